// ===== hw/rtl/glvp_pkg.sv =====
// Shared types, codes and the reciprocal square root table for the Laplacian product block.
package glvp_pkg;

    localparam int MAX_NODES   = 64;
    localparam int MAX_DEGREE  = 16;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int SLOT_W      = $clog2(MAX_DEGREE);
    localparam int DEG_W       = SLOT_W + 1;
    localparam int COUNT_W     = NODE_W + 1;
    localparam int RSQ_W       = 17;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    localparam logic [1:0] OP_WRITE_NODE = 2'd0;
    localparam logic [1:0] OP_WRITE_NB   = 2'd1;
    localparam logic [1:0] OP_COMPUTE    = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT = 1'd1;

    // Controller states, also used as datapath step codes
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_RD_NODE = 4'd1;
    localparam logic [3:0] ST_LATCH   = 4'd2;
    localparam logic [3:0] ST_RD_SLOT = 4'd3;
    localparam logic [3:0] ST_RD_NB   = 4'd4;
    localparam logic [3:0] ST_NB_MUL  = 4'd5;
    localparam logic [3:0] ST_NB_ACC  = 4'd6;
    localparam logic [3:0] ST_SCALE   = 4'd7;
    localparam logic [3:0] ST_EMIT    = 4'd8;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [5:0]        node_index;
        logic [3:0]        slot_index;
        logic [5:0]        neighbor_index;
        logic [4:0]        degree;
        logic signed [31:0] x_value;
    } glvp_req_t;

    typedef struct packed {
        logic [5:0]         result_index;
        logic signed [31:0] result_value;
        logic               saturated;
        logic               last;
    } glvp_res_t;

    typedef struct packed {
        logic [3:0]        step;
        logic [NODE_W-1:0] node;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } glvp_cmd_t;

    typedef struct packed {
        logic [DEG_W-1:0] deg_read;
        logic [DEG_W-1:0] deg_node;
    } glvp_stat_t;

    // floor(65536 / sqrt(d)), zero for degree zero
    function automatic logic [RSQ_W-1:0] rsqrt_q16(input logic [DEG_W-1:0] d);
        logic [RSQ_W-1:0] r;
        begin
            case (d)
                5'd1:    r = 17'd65536;
                5'd2:    r = 17'd46340;
                5'd3:    r = 17'd37837;
                5'd4:    r = 17'd32768;
                5'd5:    r = 17'd29308;
                5'd6:    r = 17'd26754;
                5'd7:    r = 17'd24770;
                5'd8:    r = 17'd23170;
                5'd9:    r = 17'd21845;
                5'd10:   r = 17'd20724;
                5'd11:   r = 17'd19759;
                5'd12:   r = 17'd18918;
                5'd13:   r = 17'd18176;
                5'd14:   r = 17'd17515;
                5'd15:   r = 17'd16921;
                5'd16:   r = 17'd16384;
                default: r = 17'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/glvp_ctrl.sv =====
// Sequencer that walks nodes and neighbour slots for a compute request.
module glvp_ctrl
    import glvp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         opcode,
    input  logic [COUNT_W-1:0] node_count,
    input  glvp_stat_t         stat,
    output glvp_cmd_t          cmd,
    output logic               busy
);

    logic [3:0]        state_reg, state_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [COUNT_W-1:0] count_eff;
    logic              is_last;

    assign count_eff = (node_count > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : node_count;
    assign is_last   = ({1'b0, node_reg} + COUNT_W'(1)) == count_eff;

    always_comb
    begin
        state_next = state_reg;
        node_next  = node_reg;
        slot_next  = slot_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && opcode == OP_COMPUTE && count_eff != '0)
                begin
                    state_next = ST_RD_NODE;
                    node_next  = '0;
                end
            end
            ST_RD_NODE: state_next = ST_LATCH;
            ST_LATCH:
            begin
                slot_next  = '0;
                state_next = (stat.deg_read == '0) ? ST_SCALE : ST_RD_SLOT;
            end
            ST_RD_SLOT: state_next = ST_RD_NB;
            ST_RD_NB:   state_next = ST_NB_MUL;
            ST_NB_MUL:  state_next = ST_NB_ACC;
            ST_NB_ACC:
            begin
                slot_next = slot_reg + SLOT_W'(1);
                if (({1'b0, slot_reg} + DEG_W'(1)) == stat.deg_node)
                    state_next = ST_SCALE;
                else
                    state_next = ST_RD_SLOT;
            end
            ST_SCALE: state_next = ST_EMIT;
            ST_EMIT:
            begin
                node_next  = node_reg + NODE_W'(1);
                state_next = is_last ? ST_IDLE : ST_RD_NODE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            node_reg  <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            node_reg  <= node_next;
            slot_reg  <= slot_next;
        end
    end

    assign cmd.step = state_reg;
    assign cmd.node = node_reg;
    assign cmd.slot = slot_reg;
    assign cmd.last = is_last;
    assign busy     = (state_reg != ST_IDLE);

endmodule

// ===== hw/rtl/glvp_dpath.sv =====
// Graph stores, accumulator, multipliers and result register.
module glvp_dpath
    import glvp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  glvp_req_t  req,
    input  logic       normalized_mode,
    input  glvp_cmd_t  cmd,
    output glvp_stat_t stat,
    output logic       result_valid,
    output glvp_res_t  result
);

    logic [31:0]       vec_mem [MAX_NODES];
    logic [DEG_W-1:0]  deg_mem [MAX_NODES];
    logic [NODE_W-1:0] nb_mem  [MAX_NODES*MAX_DEGREE];

    logic signed [31:0] vec_rd_reg;
    logic [DEG_W-1:0]   deg_rd_reg;
    logic [NODE_W-1:0]  nb_rd_reg;
    logic signed [31:0] xk_reg;
    logic [DEG_W-1:0]   dk_reg;
    logic signed [37:0] acc_reg, acc_next;
    logic signed [49:0] prod_reg, prod_next;
    logic signed [55:0] prod2_reg, prod2_next;
    logic               result_valid_reg;
    glvp_res_t          result_reg, result_next;

    logic               wr_node, wr_nb, rd_node, rd_slot;
    logic [NODE_W-1:0]  rd_addr;
    logic [DEG_W-1:0]   deg_clamped;
    logic signed [37:0] dx;
    logic signed [49:0] term;
    logic signed [55:0] scaled;
    logic signed [40:0] y;

    assign wr_node = accept && req.opcode == OP_WRITE_NODE;
    assign wr_nb   = accept && req.opcode == OP_WRITE_NB;
    assign rd_node = cmd.step == ST_RD_NODE || cmd.step == ST_RD_NB;
    assign rd_slot = cmd.step == ST_RD_SLOT;
    assign rd_addr = (cmd.step == ST_RD_NODE) ? cmd.node : nb_rd_reg;
    assign deg_clamped = (req.degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : req.degree;

    always_ff @(posedge clk)
    begin
        if (wr_node)
        begin
            vec_mem[req.node_index] <= req.x_value;
            deg_mem[req.node_index] <= deg_clamped;
        end
        if (wr_nb)
            nb_mem[{req.node_index, req.slot_index}] <= req.neighbor_index;
        if (rd_node)
        begin
            vec_rd_reg <= vec_mem[rd_addr];
            deg_rd_reg <= deg_mem[rd_addr];
        end
        if (rd_slot)
            nb_rd_reg <= nb_mem[{cmd.node, cmd.slot}];
    end

    assign dx     = $signed({1'b0, deg_rd_reg}) * vec_rd_reg;
    assign term   = (prod_reg + 50'sd32768) >>> 16;
    assign scaled = (prod2_reg + 56'sd32768) >>> 16;
    assign prod_next  = vec_rd_reg * $signed({1'b0, rsqrt_q16(deg_rd_reg)});
    assign prod2_next = acc_reg * $signed({1'b0, rsqrt_q16(dk_reg)});

    always_comb
    begin
        acc_next = acc_reg;
        case (cmd.step)
            ST_LATCH:  acc_next = normalized_mode ? '0 : dx;
            ST_NB_MUL: if (!normalized_mode) acc_next = acc_reg - 38'(vec_rd_reg);
            ST_NB_ACC: if (normalized_mode) acc_next = acc_reg + 38'(term);
            default:   acc_next = acc_reg;
        endcase
    end

    assign y = normalized_mode ? (41'(xk_reg) - 41'(scaled)) : 41'(acc_reg);

    always_comb
    begin
        result_next.result_index = cmd.node;
        result_next.last         = cmd.last;
        if (y > 41'sd2147483647)
        begin
            result_next.result_value = 32'sh7FFFFFFF;
            result_next.saturated    = 1'b1;
        end
        else if (y < -41'sd2147483648)
        begin
            result_next.result_value = 32'sh80000000;
            result_next.saturated    = 1'b1;
        end
        else
        begin
            result_next.result_value = 32'(y);
            result_next.saturated    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.step == ST_LATCH)
        begin
            xk_reg <= vec_rd_reg;
            dk_reg <= deg_rd_reg;
        end
        if (cmd.step == ST_NB_MUL)
            prod_reg <= prod_next;
        if (cmd.step == ST_SCALE)
            prod2_reg <= prod2_next;
        if (cmd.step == ST_EMIT)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= (cmd.step == ST_EMIT);
    end

    assign stat.deg_read = deg_rd_reg;
    assign stat.deg_node = dk_reg;
    assign result_valid  = result_valid_reg;
    assign result        = result_reg;

endmodule

// ===== hw/rtl/graph_laplacian_vector_product.sv =====
// Top level of the graph Laplacian times vector block.
// A request is taken on a rising edge with start high and busy low. Write
// requests (node degree and value, neighbour slot) complete on that edge and
// leave busy low, so they may stream one per cycle. A compute request with
// node_count nonzero raises busy and walks nodes 0 to min(node_count,64)-1
// in order, emitting one result per node on result with result_valid high
// for a single cycle; the receiver must take it then, there is no hold-off.
// The walk is paced by single-port stores read one at a time: each node
// steps through node read, latch, scale and emit, with slot read, neighbour
// read, multiply and accumulate per neighbour slot between latch and scale.
// result.last marks the final node, with busy already low in that cycle.
// Results are Q16.16 and clip to 32 bits with result.saturated set. Stores
// are undefined until written. Write configuration only while busy is low.
module graph_laplacian_vector_product
    import glvp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  glvp_req_t              request,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   result_valid,
    output glvp_res_t              result
);

    logic               mode_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               accept;
    glvp_cmd_t          cmd;
    glvp_stat_t         stat;

    assign accept = start && !busy;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            count_reg <= COUNT_W'(MAX_NODES);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[0];
                CFG_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    glvp_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (request.opcode),
        .node_count (count_reg),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy)
    );

    glvp_dpath u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .req             (request),
        .normalized_mode (mode_reg),
        .cmd             (cmd),
        .stat            (stat),
        .result_valid    (result_valid),
        .result          (result)
    );

endmodule

// ===== hw/rtl/glvp_checker.sv =====
// Port-level checks for the Laplacian product block, bound to the top level.
module glvp_checker
    import glvp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input glvp_req_t request,
    input logic      result_valid,
    input glvp_res_t result
);

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy)
        else $error("busy still high on final result");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> busy)
        else $error("busy low before final result");

    a_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("results in consecutive cycles");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.opcode != OP_COMPUTE |=> !busy)
        else $error("write request raised busy");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            (result.result_value == 32'sh7FFFFFFF || result.result_value == 32'sh80000000))
        else $error("saturated result not at a limit");

endmodule

bind graph_laplacian_vector_product glvp_checker u_glvp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
);

// ===== bench/graph_laplacian_vector_product_tb.sv =====
// Self-checking bench for the graph Laplacian times vector block.
`timescale 1ns / 1ps

module graph_laplacian_vector_product_tb;
    import glvp_pkg::*;

    // Tracks the graph held in the block and predicts each node product.
    class laplacian_scoreboard;
        logic signed [31:0] x_mem [MAX_NODES];
        logic [4:0]         deg_mem [MAX_NODES];
        logic [5:0]         nb_mem [MAX_NODES*MAX_DEGREE];
        bit                 nb_set [MAX_NODES*MAX_DEGREE];
        bit                 norm_mode;
        int unsigned        nodes_in_use;
        glvp_res_t          products [$];
        int                 failures;
        int                 seen;
        int                 sat_seen;

        function new();
            norm_mode    = 0;
            nodes_in_use = 64;
            failures     = 0;
            seen         = 0;
            sat_seen     = 0;
        endfunction

        function void configure(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_MODE)
                norm_mode = val[0];
            else
                nodes_in_use = val;
        endfunction

        // Count the neighbour slots of a node written in order from slot 0.
        function int unsigned ready_slots(int unsigned n);
            int unsigned c;
            c = 0;
            while (c < MAX_DEGREE && nb_set[n*MAX_DEGREE + c])
                c++;
            return c;
        endfunction

        // floor(65536/sqrt(d)) by search, zero for an isolated node
        function longint inv_root(int unsigned d);
            longint lo;
            longint hi;
            longint mid;
            lo = 0;
            hi = 65536;
            if (d == 0)
                return 0;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                if (mid * mid * d <= 64'd4294967296)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            return lo;
        endfunction

        function longint rnd16(longint v);
            return (v + 32768) >>> 16;
        endfunction

        function void note_request(glvp_req_t r);
            int unsigned count;
            longint      acc;
            longint      s;
            int unsigned dk;
            int unsigned m;
            glvp_res_t   y;
            case (r.opcode)
                OP_WRITE_NODE:
                begin
                    x_mem[r.node_index]   = r.x_value;
                    deg_mem[r.node_index] = (r.degree > MAX_DEGREE) ? MAX_DEGREE : r.degree;
                end
                OP_WRITE_NB:
                begin
                    nb_mem[r.node_index*MAX_DEGREE + r.slot_index] = r.neighbor_index;
                    nb_set[r.node_index*MAX_DEGREE + r.slot_index] = 1'b1;
                end
                OP_COMPUTE:
                begin
                    count = (nodes_in_use > MAX_NODES) ? MAX_NODES : nodes_in_use;
                    for (int k = 0; k < count; k++)
                    begin
                        dk = deg_mem[k];
                        if (!norm_mode)
                        begin
                            acc = longint'(dk) * longint'(x_mem[k]);
                            for (int j = 0; j < dk; j++)
                                acc -= longint'(x_mem[nb_mem[k*MAX_DEGREE + j]]);
                        end
                        else
                        begin
                            s = 0;
                            for (int j = 0; j < dk; j++)
                            begin
                                m = nb_mem[k*MAX_DEGREE + j];
                                s += rnd16(longint'(x_mem[m]) * inv_root(deg_mem[m]));
                            end
                            acc = longint'(x_mem[k]) - rnd16(s * inv_root(dk));
                        end
                        y.saturated = 1'b1;
                        if (acc > 64'sd2147483647)
                            acc = 64'sd2147483647;
                        else if (acc < -64'sd2147483648)
                            acc = -64'sd2147483648;
                        else
                            y.saturated = 1'b0;
                        y.result_index = k[5:0];
                        y.result_value = acc[31:0];
                        y.last         = (k + 1 == count);
                        products.push_back(y);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(glvp_res_t got);
            glvp_res_t want;
            if (products.size() == 0)
            begin
                $error("result for node %0d with no product outstanding", got.result_index);
                failures++;
                return;
            end
            want = products.pop_front();
            seen++;
            if (want.saturated)
                sat_seen++;
            if (got.result_index !== want.result_index)
            begin
                $error("result_index: expected %0d, got %0d", want.result_index,
                       got.result_index);
                failures++;
            end
            if (got.result_value !== want.result_value)
            begin
                $error("result_value: expected %0d, got %0d", want.result_value,
                       got.result_value);
                failures++;
            end
            if (got.saturated !== want.saturated)
            begin
                $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
                failures++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    glvp_req_t              request;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   result_valid;
    glvp_res_t              result;

    laplacian_scoreboard sb;
    int                  requests_sent;
    int                  computes_sent;
    bit                  calm_stretch;

    graph_laplacian_vector_product DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Results cannot be held off: take every strobe at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    // Present one request; called and returning at a falling edge. Busy only
    // moves on a rising edge, so its value now is what the next edge sees.
    task automatic send(input glvp_req_t r);
        while (busy)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        sb.note_request(r);
        requests_sent++;
        if (r.opcode == OP_COMPUTE)
            computes_sent++;
        @(negedge clk);
    endtask

    // Drop start and wait, about 23 times in a hundred, outside the calm stretch.
    task automatic maybe_pause();
        if (!calm_stretch && $urandom_range(99) < 23)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    // Write one register once the block has drained its last product.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        start <= 1'b0;
        @(negedge clk);
        while (sb.products.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.configure(idx, val);
    endtask

    function automatic glvp_req_t make_req(logic [1:0] op, int node, int slot, int nb,
                                           int deg, logic [31:0] x);
        glvp_req_t r;
        r.opcode         = op;
        r.node_index     = node;
        r.slot_index     = slot;
        r.neighbor_index = nb;
        r.degree         = deg;
        r.x_value        = x;
        return r;
    endfunction

    // Random request: mostly loads, some computes, a little unused-opcode noise.
    // Degrees stay within the slots already written for the node, and neighbour
    // writes often extend that run of written slots.
    function automatic glvp_req_t random_req();
        glvp_req_t   r;
        int unsigned roll;
        int unsigned node;
        int unsigned deg;
        int unsigned ready;
        int unsigned slot;
        logic [31:0] x;
        roll = $urandom_range(99);
        case ($urandom_range(3))
            0:       x = $urandom;
            1:       x = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: x = {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
        endcase
        node  = $urandom_range(63);
        ready = sb.ready_slots(node);
        deg   = ($urandom_range(9) == 0) ? $urandom_range(17, 31) : $urandom_range(16);
        if (((deg > MAX_DEGREE) ? MAX_DEGREE : deg) > ready)
            deg = ready;
        if ($urandom_range(1) == 0)
            slot = $urandom_range(15);
        else
            slot = (ready < MAX_DEGREE) ? ready : MAX_DEGREE - 1;
        r = make_req(OP_WRITE_NODE, node, slot, $urandom_range(63), deg, x);
        if (roll >= 45 && roll < 85)
            r.opcode = OP_WRITE_NB;
        else if (roll >= 85 && roll < 96)
            r.opcode = OP_COMPUTE;
        else if (roll >= 96)
            r.opcode = 2'd3;
        return r;
    endfunction

    initial
    begin
        int node_count_val;

        sb            = new();
        requests_sent = 0;
        computes_sent = 0;
        calm_stretch  = 1'b1;
        rst_n         = 1'b0;
        start         = 1'b0;
        request       = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_MODE;
        cfg_data      = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill every node record and enough neighbour slots that no compute
        // reads an unwritten entry; nodes 0 and 1 get full lists.
        for (int n = 0; n < MAX_NODES; n++)
        begin
            send(make_req(OP_WRITE_NODE, n, 0, 0,
                          (n < 2) ? $urandom_range(16) : $urandom_range(2), $urandom));
            for (int s = 0; s < ((n < 2) ? MAX_DEGREE : 2); s++)
                send(make_req(OP_WRITE_NB, n, s, $urandom_range(63), 0, 0));
        end

        // Directed: field extremes, clamped degree, isolated node, ignored
        // opcode, out-of-range counts, both modes.
        send(make_req(OP_WRITE_NODE, 0, 15, 63, 31, 32'h7FFF_FFFF));
        send(make_req(OP_WRITE_NODE, 1, 0, 0, 16, 32'h8000_0000));
        send(make_req(OP_WRITE_NODE, 2, 0, 0, 0, 32'h0001_0000));
        send(make_req(OP_WRITE_NODE, 63, 0, 0, 1, 32'hFFFF_FFFF));
        send(make_req(OP_WRITE_NB, 0, 0, 1, 0, 0));
        send(make_req(OP_WRITE_NB, 1, 15, 63, 0, 0));
        send(make_req(OP_WRITE_NB, 63, 0, 2, 0, 0));
        send(make_req(2'd3, 63, 15, 63, 31, 32'hFFFF_FFFF));
        send(make_req(OP_COMPUTE, 0, 0, 0, 0, 0));
        write_reg(CFG_MODE, 7'd1);
        send(make_req(OP_COMPUTE, 63, 15, 63, 31, 32'hFFFF_FFFF));
        write_reg(CFG_COUNT, 7'd1);
        send(make_req(OP_COMPUTE, 0, 0, 0, 0, 0));
        write_reg(CFG_MODE, 7'b1111110);
        send(make_req(OP_COMPUTE, 0, 0, 0, 0, 0));
        write_reg(CFG_COUNT, 7'd0);
        send(make_req(OP_COMPUTE, 0, 0, 0, 0, 0));
        write_reg(CFG_COUNT, 7'd127);
        send(make_req(OP_COMPUTE, 0, 0, 0, 0, 0));

        // Random phases, each under a fresh setting; small node counts keep
        // computes short, with the odd full or out-of-range count.
        for (int phase = 0; phase < 10; phase++)
        begin
            case ($urandom_range(9))
                0:       node_count_val = 64;
                1:       node_count_val = $urandom_range(65, 127);
                2:       node_count_val = 0;
                3:       node_count_val = $urandom_range(13, 63);
                default: node_count_val = $urandom_range(1, 12);
            endcase
            write_reg(CFG_MODE, 7'($urandom));
            write_reg(CFG_COUNT, node_count_val);
            for (int i = 0; i < 30; i++)
            begin
                calm_stretch = (phase == 3);
                maybe_pause();
                send(random_req());
            end
        end

        // Drain, then wait for any stray strobe.
        start <= 1'b0;
        while (sb.products.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Covered %0d requests (%0d computes) with %0d node products, %0d clipped.",
                 requests_sent, computes_sent, sb.seen, sb.sat_seen);
        if (sb.failures == 0)
            $display("graph_laplacian_vector_product verification clean");
        else
            $display("graph_laplacian_vector_product verification failed");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #30_000_000;
        $display("graph_laplacian_vector_product verification failed");
        $finish;
    end

endmodule
